// ===== rtl/gmb_pkg.sv =====
// gmb_pkg: beat types, register indexes and controller/datapath links
// for the greedy meshlet builder; no dependencies
package gmb_pkg;

  // remap entry that maps to no local vertex
  localparam logic [7:0] UNUSED_MARK = 8'hff;

  // configuration register indexes
  localparam logic REG_MAX_VERTICES  = 1'b0;
  localparam logic REG_MAX_TRIANGLES = 1'b1;

  // one triangle beat
  typedef struct packed {
    logic [15:0] corner_a;
    logic [15:0] corner_b;
    logic [15:0] corner_c;
    logic        final_triangle;
  } tri_t;

  // one result beat
  typedef struct packed {
    logic [15:0] meshlet_number;
    logic        opened_meshlet;
    logic [5:0]  local_a;
    logic [5:0]  local_b;
    logic [5:0]  local_c;
    logic [2:0]  new_corner_mask;
    logic [6:0]  vertices_used;
    logic [6:0]  triangle_slot;
    logic        stream_done;
    logic        range_error;
  } res_t;

  // controller to datapath
  typedef struct packed {
    logic clear_step;
    logic load;
    logic rd_a;
    logic rd_b;
    logic rd_c;
    logic decide;
    logic walk;
    logic close_mid;
    logic close_fin;
    logic app_a;
    logic app_b;
    logic app_c;
    logic snap;
    logic emit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;
    logic err;
    logic fin;
    logic need_close;
    logic walk_done;
    logic out_free;
  } stat_t;

endpackage

// ===== rtl/gmb_ram.sv =====
// gmb_ram: generic single-port ram with registered read
// no dependencies
module gmb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read on one port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/gmb_ctrl.sv =====
// gmb_ctrl: sequencing state machine of the meshlet builder
// depends on gmb_pkg
module gmb_ctrl
  import gmb_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  tri_valid,
  output logic  tri_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [11:0] {
    S_CLEAR    = 12'b000000000001,
    S_IDLE     = 12'b000000000010,
    S_RD_A     = 12'b000000000100,
    S_RD_B     = 12'b000000001000,
    S_RD_C     = 12'b000000010000,
    S_DECIDE   = 12'b000000100000,
    S_WALK_MID = 12'b000001000000,
    S_APP_A    = 12'b000010000000,
    S_APP_B    = 12'b000100000000,
    S_APP_C    = 12'b001000000000,
    S_WALK_FIN = 12'b010000000000,
    S_EMIT     = 12'b100000000000
  } state_t;

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign tri_stall = (state != S_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (stat.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (tri_valid) begin
          cmd.load   = 1'b1;
          state_next = S_RD_A;
        end
      end
      S_RD_A: begin
        if (stat.err) begin
          cmd.snap   = 1'b1;
          state_next = stat.fin ? S_WALK_FIN : S_EMIT;
        end else begin
          cmd.rd_a   = 1'b1;
          state_next = S_RD_B;
        end
      end
      S_RD_B: begin
        cmd.rd_b   = 1'b1;
        state_next = S_RD_C;
      end
      S_RD_C: begin
        cmd.rd_c   = 1'b1;
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_next = stat.need_close ? S_WALK_MID : S_APP_A;
      end
      S_WALK_MID: begin
        cmd.walk = 1'b1;
        if (stat.walk_done) begin
          cmd.close_mid = 1'b1;
          state_next    = S_APP_A;
        end
      end
      S_APP_A: begin
        cmd.app_a  = 1'b1;
        state_next = S_APP_B;
      end
      S_APP_B: begin
        cmd.app_b  = 1'b1;
        state_next = S_APP_C;
      end
      S_APP_C: begin
        cmd.app_c  = 1'b1;
        cmd.snap   = 1'b1;
        state_next = stat.fin ? S_WALK_FIN : S_EMIT;
      end
      S_WALK_FIN: begin
        cmd.walk = 1'b1;
        if (stat.walk_done) begin
          cmd.close_fin = 1'b1;
          state_next    = S_EMIT;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

endmodule

// ===== rtl/gmb_datapath.sv =====
// gmb_datapath: remap and local list memories, counters, limits and result register
// depends on gmb_pkg and gmb_ram
module gmb_datapath
  import gmb_pkg::*;
#(
  parameter int VERTEX_SPACE = 65536,
  parameter int MAX_VERTS    = 64,
  parameter int MAX_TRIS     = 128
) (
  input  logic       clk,
  input  logic       rst,
  input  tri_t       tri_data,
  output res_t       res_data,
  output logic       res_valid,
  input  logic       res_stall,
  input  logic       cfg_write,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  input  cmd_t       cmd,
  output stat_t      stat
);

  localparam int AW = $clog2(VERTEX_SPACE);
  localparam int LW = $clog2(MAX_VERTS);
  localparam int VW = $clog2(MAX_VERTS + 1);
  localparam int TW = $clog2(MAX_TRIS + 1);

  function automatic logic [AW-1:0] to_addr(input logic [15:0] g);
    logic [AW+15:0] w;
    w = {{AW{1'b0}}, g};
    return w[AW-1:0];
  endfunction

  // control state
  logic [AW-1:0] clr_cnt;
  logic [VW-1:0] vt, vt_next;
  logic [TW-1:0] tt;
  logic [15:0]   mc;
  logic [VW-1:0] j;
  logic          pend;
  logic [6:0]    max_vertices;
  logic [7:0]    max_triangles;

  // payload state
  tri_t        in_reg;
  logic        err;
  logic [7:0]  va, vb, vc;
  logic [7:0]  loc_a, loc_b, loc_c;
  logic [2:0]  mask;
  logic        opened;
  logic [6:0]  slot;
  logic [6:0]  res_vt;
  logic [15:0] res_num;

  // memory ports
  logic          rm_we;
  logic [AW-1:0] rm_addr;
  logic [7:0]    rm_wd, rm_rd;
  logic          ls_we;
  logic [LW-1:0] ls_addr;
  logic [15:0]   ls_rd;

  // append path
  logic        app_any;
  logic [15:0] cur_g;
  logic [7:0]  cur_v, new_v;
  logic        do_app;

  // limits and decision
  logic [8:0] vlim;
  logic [9:0] tlim;
  logic [1:0] fresh;
  logic       in_err;

  gmb_ram #(.WIDTH(8), .DEPTH(VERTEX_SPACE)) u_remap (
    .clk(clk), .we(rm_we), .addr(rm_addr), .wdata(rm_wd), .rdata(rm_rd)
  );

  gmb_ram #(.WIDTH(16), .DEPTH(MAX_VERTS)) u_list (
    .clk(clk), .we(ls_we), .addr(ls_addr), .wdata(cur_g), .rdata(ls_rd)
  );

  // clamped limits
  always_comb begin
    if (max_vertices < 7'd3) begin
      vlim = 9'd3;
    end else if (9'(max_vertices) > 9'(MAX_VERTS)) begin
      vlim = 9'(MAX_VERTS);
    end else begin
      vlim = 9'(max_vertices);
    end
    if (max_triangles == 8'd0) begin
      tlim = 10'd1;
    end else if (10'(max_triangles) > 10'(MAX_TRIS)) begin
      tlim = 10'(MAX_TRIS);
    end else begin
      tlim = 10'(max_triangles);
    end
  end

  // unused corners, counted with repeats; corner c comes straight off the ram
  assign fresh = 2'(va == UNUSED_MARK) + 2'(vb == UNUSED_MARK) + 2'(rm_rd == UNUSED_MARK);

  assign in_err = (32'(tri_data.corner_a) >= 32'(VERTEX_SPACE)) ||
                  (32'(tri_data.corner_b) >= 32'(VERTEX_SPACE)) ||
                  (32'(tri_data.corner_c) >= 32'(VERTEX_SPACE));

  // corner being appended, with forwarding from earlier corners of the triangle
  always_comb begin
    app_any = cmd.app_a | cmd.app_b | cmd.app_c;
    cur_g   = in_reg.corner_a;
    cur_v   = va;
    if (cmd.app_b) begin
      cur_g = in_reg.corner_b;
      cur_v = (in_reg.corner_b == in_reg.corner_a) ? loc_a : vb;
    end else if (cmd.app_c) begin
      cur_g = in_reg.corner_c;
      if (in_reg.corner_c == in_reg.corner_b) begin
        cur_v = loc_b;
      end else if (in_reg.corner_c == in_reg.corner_a) begin
        cur_v = loc_a;
      end else begin
        cur_v = vc;
      end
    end
    do_app  = app_any && (cur_v == UNUSED_MARK) && (vt < VW'(MAX_VERTS));
    new_v   = do_app ? 8'(vt) : cur_v;
    vt_next = do_app ? vt + VW'(1) : vt;
  end

  // remap port selection
  always_comb begin
    rm_we   = 1'b0;
    rm_addr = to_addr(in_reg.corner_a);
    rm_wd   = UNUSED_MARK;
    if (cmd.clear_step) begin
      rm_we   = 1'b1;
      rm_addr = clr_cnt;
    end else if (cmd.rd_b) begin
      rm_addr = to_addr(in_reg.corner_b);
    end else if (cmd.rd_c) begin
      rm_addr = to_addr(in_reg.corner_c);
    end else if (cmd.walk) begin
      rm_we   = pend;
      rm_addr = to_addr(ls_rd);
    end else if (app_any) begin
      rm_we   = do_app;
      rm_addr = to_addr(cur_g);
      rm_wd   = 8'(vt);
    end
  end

  // local list port
  assign ls_we   = do_app;
  assign ls_addr = cmd.walk ? j[LW-1:0] : vt[LW-1:0];

  // status
  assign stat.clear_last = (clr_cnt == AW'(VERTEX_SPACE - 1));
  assign stat.err        = err;
  assign stat.fin        = in_reg.final_triangle;
  assign stat.need_close = ((9'(vt) + 9'(fresh)) > vlim) || ((10'(tt) + 10'd1) > tlim);
  assign stat.walk_done  = !(j < vt) && !pend;
  assign stat.out_free   = !res_valid || !res_stall;

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt       <= '0;
      vt            <= '0;
      tt            <= '0;
      mc            <= '0;
      j             <= '0;
      pend          <= 1'b0;
      res_valid     <= 1'b0;
      max_vertices  <= 7'd64;
      max_triangles <= 8'd126;
    end else begin
      if (cfg_write && cfg_index == REG_MAX_VERTICES) max_vertices <= cfg_data[6:0];
      if (cfg_write && cfg_index == REG_MAX_TRIANGLES) max_triangles <= cfg_data;
      if (cmd.clear_step) clr_cnt <= clr_cnt + AW'(1);
      // close walk: read one list entry a cycle, clear its remap entry the next
      if (cmd.walk) begin
        if (j < vt) begin
          j    <= j + VW'(1);
          pend <= 1'b1;
        end else begin
          pend <= 1'b0;
        end
      end
      if (app_any) vt <= vt_next;
      if (cmd.app_c) tt <= tt + TW'(1);
      if (cmd.close_mid || cmd.close_fin) begin
        vt <= '0;
        tt <= '0;
        j  <= '0;
      end
      if (cmd.close_mid) mc <= mc + 16'd1;
      if (cmd.close_fin) mc <= '0;
      if (cmd.emit) begin
        res_valid <= 1'b1;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_reg <= tri_data;
      err    <= in_err;
      loc_a  <= '0;
      loc_b  <= '0;
      loc_c  <= '0;
      mask   <= '0;
      opened <= 1'b0;
      slot   <= '0;
    end
    if (cmd.rd_b) va <= rm_rd;
    if (cmd.rd_c) vb <= rm_rd;
    if (cmd.decide) vc <= rm_rd;
    if (cmd.close_mid) begin
      va     <= UNUSED_MARK;
      vb     <= UNUSED_MARK;
      vc     <= UNUSED_MARK;
      opened <= 1'b1;
    end
    if (cmd.app_a) begin
      loc_a   <= new_v;
      mask[0] <= do_app;
    end
    if (cmd.app_b) begin
      loc_b   <= new_v;
      mask[1] <= do_app;
    end
    if (cmd.app_c) begin
      loc_c   <= new_v;
      mask[2] <= do_app;
      slot    <= 7'(tt);
    end
    if (cmd.snap) begin
      res_vt  <= 7'(vt_next);
      res_num <= mc;
    end
    if (cmd.emit) begin
      res_data.meshlet_number  <= res_num;
      res_data.opened_meshlet  <= opened;
      res_data.local_a         <= loc_a[5:0];
      res_data.local_b         <= loc_b[5:0];
      res_data.local_c         <= loc_c[5:0];
      res_data.new_corner_mask <= mask;
      res_data.vertices_used   <= res_vt;
      res_data.triangle_slot   <= slot;
      res_data.stream_done     <= in_reg.final_triangle;
      res_data.range_error     <= err;
    end
  end

endmodule

// ===== rtl/greedy_meshlet_builder.sv =====
// greedy_meshlet_builder: top level joining controller and datapath
// depends on gmb_pkg, gmb_ctrl, gmb_datapath (and gmb_ram below it)
//
// Usage:
//  - tri channel: one triangle a beat (three global corners and a final mark),
//    taken on a clock edge with tri_valid high and tri_stall low
//  - res channel: one result beat per triangle, in order, held while res_stall
//  - cfg port: cfg_write with cfg_index 0 (max_vertices) or 1 (max_triangles);
//    write only while idle
//  - a triangle passes states RD_A, RD_B, RD_C, DECIDE, APP_A, APP_B and APP_C
//    before EMIT loads its result register (a dropped out-of-range triangle
//    leaves after RD_A); the next one is taken only after EMIT, the pace set
//    by the single remap ram port (three reads, then up to three writes)
//  - closing a meshlet walks its local list, one entry a cycle on that same
//    port, before adding the triangle and again after a final triangle
//  - after reset the remap ram is cleared in full, one entry a cycle;
//    tri_stall stays high meanwhile, config writes are still taken
//  - while res_stall holds the result register full, a new triangle may still
//    be accepted; it waits for the register before its result is loaded
module greedy_meshlet_builder
  import gmb_pkg::*;
#(
  parameter int VERTEX_SPACE = 65536,
  parameter int MAX_VERTS    = 64,
  parameter int MAX_TRIS     = 128
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       tri_valid,
  output logic       tri_stall,
  input  tri_t       tri_data,
  output logic       res_valid,
  input  logic       res_stall,
  output res_t       res_data,
  input  logic       cfg_write,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data
);

  cmd_t  cmd;
  stat_t stat;

  gmb_ctrl u_ctrl (
    .clk(clk), .rst(rst), .tri_valid(tri_valid), .tri_stall(tri_stall),
    .stat(stat), .cmd(cmd)
  );

  gmb_datapath #(
    .VERTEX_SPACE(VERTEX_SPACE), .MAX_VERTS(MAX_VERTS), .MAX_TRIS(MAX_TRIS)
  ) u_dp (
    .clk(clk), .rst(rst), .tri_data(tri_data), .res_data(res_data),
    .res_valid(res_valid), .res_stall(res_stall), .cfg_write(cfg_write),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .cmd(cmd), .stat(stat)
  );

  // at most one step of the sequence at a time
  a_one_step: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.clear_step, cmd.load, cmd.rd_a, cmd.rd_b, cmd.rd_c, cmd.decide,
              cmd.walk, cmd.app_a, cmd.app_b, cmd.app_c, cmd.emit}))
    else $error("more than one step commanded");

  // no triangle is taken during the clearing pass
  a_clear_stall: assert property (@(posedge clk) disable iff (rst)
    cmd.clear_step |-> tri_stall)
    else $error("triangle accepted while clearing");

  // a mid-stream close is followed by the first append
  a_close_append: assert property (@(posedge clk) disable iff (rst)
    cmd.close_mid |=> cmd.app_a)
    else $error("close not followed by append");

  // an emitted result only lands in a free result register
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!res_valid || !res_stall))
    else $error("result overwritten while stalled");

endmodule

// ===== tb/greedy_meshlet_builder_checker.sv =====
// greedy_meshlet_builder_checker: watches triangle, result and config traffic,
// predicts each result beat and compares it field by field; depends on gmb_pkg
`timescale 1ns / 1ps

module greedy_meshlet_builder_checker
  import gmb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       tri_valid,
  input  logic       tri_stall,
  input  tri_t       tri_data,
  input  logic       res_valid,
  input  logic       res_stall,
  input  res_t       res_data,
  input  logic       cfg_write,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  output int         fail_count,
  output int         pending,
  output int         splits_seen,
  output int         results_seen
);

  localparam int VSPACE = 65536;
  localparam int NVERT  = 64;
  localparam int NTRI   = 128;

  logic [7:0]  remap [VSPACE];
  logic [15:0] vlist [NVERT];
  int          vert_count;
  int          tri_count;
  logic [15:0] meshlet_idx;
  logic [6:0]  lim_verts_reg;
  logic [7:0]  lim_tris_reg;
  res_t        expected_q[$];

  // release every remap entry the open meshlet holds
  function automatic void release_meshlet();
    for (int j = 0; j < vert_count; j++) remap[vlist[j]] = UNUSED_MARK;
    vert_count = 0;
    tri_count  = 0;
  endfunction

  function automatic res_t build_meshlet_result(tri_t t);
    res_t        r;
    logic [15:0] cs[3];
    int          fresh;
    int          vlim;
    int          tlim;
    r = '0;
    cs[0] = t.corner_a;
    cs[1] = t.corner_b;
    cs[2] = t.corner_c;
    vlim = lim_verts_reg < 3 ? 3 : (lim_verts_reg > NVERT ? NVERT : lim_verts_reg);
    tlim = lim_tris_reg < 1 ? 1 : (lim_tris_reg > NTRI ? NTRI : lim_tris_reg);
    fresh = 0;
    for (int k = 0; k < 3; k++) if (remap[cs[k]] == UNUSED_MARK) fresh++;
    // close the open meshlet when this triangle would overflow it
    if (vert_count + fresh > vlim || tri_count + 1 > tlim) begin
      release_meshlet();
      meshlet_idx++;
      r.opened_meshlet = 1'b1;
      splits_seen++;
    end
    for (int k = 0; k < 3; k++) begin
      if (remap[cs[k]] == UNUSED_MARK && vert_count < NVERT) begin
        remap[cs[k]] = vert_count[7:0];
        vlist[vert_count] = cs[k];
        vert_count++;
        r.new_corner_mask[k] = 1'b1;
      end
    end
    r.local_a = remap[cs[0]][5:0];
    r.local_b = remap[cs[1]][5:0];
    r.local_c = remap[cs[2]][5:0];
    r.triangle_slot = tri_count[6:0];
    tri_count++;
    r.meshlet_number = meshlet_idx;
    r.vertices_used  = vert_count[6:0];
    r.stream_done    = t.final_triangle;
    r.range_error    = 1'b0;
    if (t.final_triangle) begin
      release_meshlet();
      meshlet_idx = '0;
    end
    return r;
  endfunction

  function automatic void compare_field(string nm, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", nm, exp_v, act_v);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    res_t e;
    if (rst) begin
      for (int i = 0; i < VSPACE; i++) remap[i] = UNUSED_MARK;
      vert_count = 0;
      tri_count = 0;
      meshlet_idx = '0;
      lim_verts_reg = 7'd64;
      lim_tris_reg = 8'd126;
      expected_q.delete();
      fail_count = 0;
      splits_seen = 0;
      results_seen = 0;
    end else begin
      if (cfg_write) begin
        if (cfg_index == REG_MAX_VERTICES) lim_verts_reg = cfg_data[6:0];
        else lim_tris_reg = cfg_data;
      end
      if (tri_valid && !tri_stall) expected_q.push_back(build_meshlet_result(tri_data));
      // compare each accepted result beat with the oldest prediction
      if (res_valid && !res_stall) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          $error("result beat with no triangle outstanding");
          fail_count++;
        end else begin
          e = expected_q.pop_front();
          compare_field("meshlet_number", e.meshlet_number, res_data.meshlet_number);
          compare_field("opened_meshlet", e.opened_meshlet, res_data.opened_meshlet);
          compare_field("local_a", e.local_a, res_data.local_a);
          compare_field("local_b", e.local_b, res_data.local_b);
          compare_field("local_c", e.local_c, res_data.local_c);
          compare_field("new_corner_mask", e.new_corner_mask, res_data.new_corner_mask);
          compare_field("vertices_used", e.vertices_used, res_data.vertices_used);
          compare_field("triangle_slot", e.triangle_slot, res_data.triangle_slot);
          compare_field("stream_done", e.stream_done, res_data.stream_done);
          compare_field("range_error", e.range_error, res_data.range_error);
        end
      end
    end
    pending <= expected_q.size();
  end

endmodule

// ===== tb/greedy_meshlet_builder_tb.sv =====
// greedy_meshlet_builder_tb: clock, reset, triangle stimulus and verdict;
// depends on gmb_pkg, greedy_meshlet_builder and greedy_meshlet_builder_checker
`timescale 1ns / 1ps

module greedy_meshlet_builder_tb;
  import gmb_pkg::*;

  localparam int CYCLE_LIMIT = 1500000;

  logic       clk;
  logic       rst;
  logic       tri_valid;
  logic       tri_stall;
  tri_t       tri_data;
  logic       res_valid;
  logic       res_stall;
  res_t       res_data;
  logic       cfg_write;
  logic       cfg_index;
  logic [7:0] cfg_data;
  int         fail_count;
  int         pending;
  int         splits_seen;
  int         results_seen;
  int         cycle_count;
  int         tris_sent;
  bit         steady_out;
  logic [15:0] pool[$];

  greedy_meshlet_builder u_dut (
    .clk(clk), .rst(rst),
    .tri_valid(tri_valid), .tri_stall(tri_stall), .tri_data(tri_data),
    .res_valid(res_valid), .res_stall(res_stall), .res_data(res_data),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  greedy_meshlet_builder_checker u_chk (
    .clk(clk), .rst(rst),
    .tri_valid(tri_valid), .tri_stall(tri_stall), .tri_data(tri_data),
    .res_valid(res_valid), .res_stall(res_stall), .res_data(res_data),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending),
    .splits_seen(splits_seen), .results_seen(results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result side stalls at random, except in a steady stretch
  always @(posedge clk) begin
    if (rst) res_stall <= 1'b0;
    else res_stall <= !steady_out && ($urandom_range(99) < 13);
  end

  // one triangle beat; random gaps before it when gaps is set, then hold until taken
  task automatic send_tri(logic [15:0] a, logic [15:0] b, logic [15:0] c, logic fin,
                          bit gaps);
    if (gaps) begin
      while ($urandom_range(99) < 13) begin
        tri_valid <= 1'b0;
        @(posedge clk);
      end
    end
    tri_valid <= 1'b1;
    tri_data  <= '{corner_a: a, corner_b: b, corner_c: c, final_triangle: fin};
    @(posedge clk);
    while (tri_stall) @(posedge clk);
    tris_sent++;
  endtask

  task automatic wait_idle();
    tri_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    // quiet gap before the next register write
    repeat (200) @(posedge clk);
  endtask

  // one register write, then the write enable is brought low again
  task automatic write_reg(logic idx, logic [7:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // pick a corner from a small reuse pool, now and then a fresh one
  function automatic logic [15:0] pick_corner();
    logic [15:0] v;
    if (pool.size() > 0 && $urandom_range(99) < 70) return pool[$urandom_range(pool.size() - 1)];
    v = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(300));
    pool.push_back(v);
    if (pool.size() > 40) void'(pool.pop_front());
    return v;
  endfunction

  task automatic random_mesh(int n, bit gaps);
    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] c;
    for (int i = 0; i < n; i++) begin
      a = pick_corner();
      b = ($urandom_range(19) == 0) ? a : pick_corner();
      c = pick_corner();
      send_tri(a, b, c, i == n - 1 || $urandom_range(199) == 0, gaps);
    end
  endtask

  initial begin
    int vset[6];
    int tset[6];
    tri_valid = 1'b0;
    tri_data  = '0;
    cfg_write = 1'b0;
    cfg_index = 1'b0;
    cfg_data  = '0;
    rst = 1'b1;
    steady_out = 1'b0;
    cycle_count = 0;
    tris_sent = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, repeats within a triangle, limits at their bounds
    write_reg(REG_MAX_VERTICES, 8'd0);
    write_reg(REG_MAX_TRIANGLES, 8'd0);
    send_tri(16'd0, 16'hffff, 16'h5555, 1'b0, 1'b1);
    send_tri(16'haaaa, 16'haaaa, 16'haaaa, 1'b0, 1'b1);
    send_tri(16'd0, 16'd0, 16'd1, 1'b1, 1'b1);
    wait_idle();
    write_reg(REG_MAX_VERTICES, 8'd127);
    write_reg(REG_MAX_TRIANGLES, 8'd255);
    for (int i = 0; i < 14; i++)
      send_tri(16'(3 * i), 16'(3 * i + 1), 16'(3 * i + 2), 1'b0, 1'b1);
    for (int i = 0; i < 4; i++) send_tri(16'd5, 16'd7, 16'hffff, 1'b0, 1'b1);
    send_tri(16'd200, 16'd200, 16'd201, 1'b1, 1'b1);
    wait_idle();
    write_reg(REG_MAX_VERTICES, 8'd3);
    write_reg(REG_MAX_TRIANGLES, 8'd1);
    send_tri(16'd9, 16'd9, 16'd9, 1'b0, 1'b1);
    send_tri(16'd9, 16'd8, 16'd7, 1'b1, 1'b1);
    wait_idle();

    // random meshes over several limit settings
    vset = '{64, 3, 8, 20, 64, 127};
    tset = '{126, 1, 4, 128, 2, 200};
    for (int p = 0; p < 6; p++) begin
      write_reg(REG_MAX_VERTICES, 8'(vset[p]));
      write_reg(REG_MAX_TRIANGLES, 8'(tset[p]));
      steady_out = (p == 3);
      random_mesh(250, p != 3);
      wait_idle();
    end
    // a mesh long enough to pass the triangle limit with a small vertex pool
    write_reg(REG_MAX_VERTICES, 8'd64);
    write_reg(REG_MAX_TRIANGLES, 8'd128);
    for (int i = 0; i < 130; i++)
      send_tri(16'(i % 4), 16'(i % 4 + 1), 16'(i % 4 + 2), i == 129, 1'b1);
    steady_out = 1'b0;
    wait_idle();

    $display("%0d triangles sent, %0d results checked, %0d meshlet splits",
             tris_sent, results_seen, splits_seen);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
